### design/cau_pkg.sv
// Shared widths, item types and a helper function for the complex arithmetic unit.
package cau_pkg;

    // Operand format
    localparam int DW = 32;             // width of one operand part
    localparam int FW = 16;             // fraction bits
    localparam int PW = 2 * DW;         // width of one product
    localparam int SW = 2 * DW + 1;     // width of a sum of two products
    localparam int RW = 2 * DW;         // divisor and remainder width
    localparam int QB = DW + 1;         // quotient bits worked out per part
    localparam int NW = SW + FW;        // width of a shifted numerator magnitude
    localparam int TW = NW - QB;        // numerator bits above the quotient bits

    // Saturation limits at sum width
    localparam logic signed [SW-1:0] SAT_HI = {{(SW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {{(SW - DW + 1){1'b1}}, {(DW - 1){1'b0}}};

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef struct packed {
        t_op                    opcode;
        logic signed [DW-1:0]   a_re;
        logic signed [DW-1:0]   a_im;
        logic signed [DW-1:0]   b_re;
        logic signed [DW-1:0]   b_im;
    } t_in_item;

    typedef struct packed {
        logic signed [DW-1:0]   res_re;
        logic signed [DW-1:0]   res_im;
        logic                   overflow;
        logic                   div_by_zero;
    } t_out_item;

    typedef struct packed {
        logic                   ovf;
        logic signed [DW-1:0]   val;
    } t_sat;

    // Item as it travels through the divider stages
    typedef struct packed {
        logic                   is_div;
        logic                   dbz;
        logic                   dovf_re;
        logic                   dovf_im;
        logic                   neg_re;
        logic                   neg_im;
        logic [RW-1:0]          rem_re;
        logic [RW-1:0]          rem_im;
        logic [QB-1:0]          nlo_re;
        logic [QB-1:0]          nlo_im;
        logic [QB-1:0]          q_re;
        logic [QB-1:0]          q_im;
        logic [RW-1:0]          den;
        logic signed [DW-1:0]   pre_re;
        logic signed [DW-1:0]   pre_im;
        logic                   pre_ovf;
    } t_div_item;

    // Clamp a wide signed value to the operand range
    function automatic t_sat sat(input logic signed [SW-1:0] v);
        t_sat s;
        if (v > SAT_HI) begin
            s.ovf = 1'b1;
            s.val = SAT_HI[DW-1:0];
        end else if (v < SAT_LO) begin
            s.ovf = 1'b1;
            s.val = SAT_LO[DW-1:0];
        end else begin
            s.ovf = 1'b0;
            s.val = v[DW-1:0];
        end
        return s;
    endfunction

endpackage

### design/cau_front.sv
// Front pipeline: products, sums, non-divide results and numerator preparation for the divider.
module cau_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  cau_pkg::t_in_item   i_data,
    output logic                o_ready,
    output logic                o_valid,
    output cau_pkg::t_div_item  o_data,
    input  logic                i_ready
);

    localparam int DW = cau_pkg::DW;
    localparam int FW = cau_pkg::FW;
    localparam int PW = cau_pkg::PW;
    localparam int SW = cau_pkg::SW;
    localparam int RW = cau_pkg::RW;
    localparam int QB = cau_pkg::QB;
    localparam int NW = cau_pkg::NW;
    localparam int TW = cau_pkg::TW;
    localparam int AW = DW + 1;

    typedef struct packed {
        cau_pkg::t_op           op;
        logic signed [PW-1:0]   p0;     // ar*br
        logic signed [PW-1:0]   p1;     // ai*bi
        logic signed [PW-1:0]   p2;     // ai*br
        logic signed [PW-1:0]   p3;     // ar*bi
        logic signed [PW-1:0]   p4;     // br*br
        logic signed [PW-1:0]   p5;     // bi*bi
        logic signed [AW-1:0]   s_re;
        logic signed [AW-1:0]   s_im;
    } t_prod;

    typedef struct packed {
        cau_pkg::t_op           op;
        logic signed [SW-1:0]   m_re;
        logic signed [SW-1:0]   m_im;
        logic signed [SW-1:0]   d_re;
        logic signed [SW-1:0]   d_im;
        logic [RW-1:0]          den;
        logic signed [AW-1:0]   s_re;
        logic signed [AW-1:0]   s_im;
    } t_sum;

    logic               r_v1, r_v2, r_v3;
    t_prod              r_s1, n_s1;
    t_sum               r_s2, n_s2;
    cau_pkg::t_div_item r_s3, n_s3;
    logic               w_rdy1, w_rdy2, w_rdy3;

    logic [SW-1:0]      w_mag_re, w_mag_im;
    logic [NW-1:0]      w_big_re, w_big_im;
    logic [TW-1:0]      w_top_re, w_top_im;
    cau_pkg::t_sat      w_sat_re, w_sat_im;

    // Stage enables: a stage moves when empty or when the next one moves
    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v3;
    assign o_data  = r_s3;

    // Stage 1: the six products and the plain sums
    always_comb begin
        n_s1.op = i_data.opcode;
        n_s1.p0 = PW'(i_data.a_re) * PW'(i_data.b_re);
        n_s1.p1 = PW'(i_data.a_im) * PW'(i_data.b_im);
        n_s1.p2 = PW'(i_data.a_im) * PW'(i_data.b_re);
        n_s1.p3 = PW'(i_data.a_re) * PW'(i_data.b_im);
        n_s1.p4 = PW'(i_data.b_re) * PW'(i_data.b_re);
        n_s1.p5 = PW'(i_data.b_im) * PW'(i_data.b_im);
        if (i_data.opcode == cau_pkg::OP_SUB) begin
            n_s1.s_re = AW'(i_data.a_re) - AW'(i_data.b_re);
            n_s1.s_im = AW'(i_data.a_im) - AW'(i_data.b_im);
        end else begin
            n_s1.s_re = AW'(i_data.a_re) + AW'(i_data.b_re);
            n_s1.s_im = AW'(i_data.a_im) + AW'(i_data.b_im);
        end
    end

    // Stage 2: combine products
    always_comb begin
        n_s2.op   = r_s1.op;
        n_s2.m_re = SW'(r_s1.p0) - SW'(r_s1.p1);
        n_s2.m_im = SW'(r_s1.p2) + SW'(r_s1.p3);
        n_s2.d_re = SW'(r_s1.p0) + SW'(r_s1.p1);
        n_s2.d_im = SW'(r_s1.p2) - SW'(r_s1.p3);
        n_s2.den  = $unsigned(r_s1.p4) + $unsigned(r_s1.p5);
        n_s2.s_re = r_s1.s_re;
        n_s2.s_im = r_s1.s_im;
    end

    // Stage 3: finish the non-divide results, split numerators for the divider
    always_comb begin
        w_mag_re = r_s2.d_re[SW-1] ? SW'(-r_s2.d_re) : SW'(r_s2.d_re);
        w_mag_im = r_s2.d_im[SW-1] ? SW'(-r_s2.d_im) : SW'(r_s2.d_im);
        w_big_re = NW'(w_mag_re) << FW;
        w_big_im = NW'(w_mag_im) << FW;
        w_top_re = w_big_re[NW-1:QB];
        w_top_im = w_big_im[NW-1:QB];

        case (r_s2.op)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
                w_sat_re = cau_pkg::sat(SW'(r_s2.s_re));
                w_sat_im = cau_pkg::sat(SW'(r_s2.s_im));
            end
            cau_pkg::OP_MUL: begin
                w_sat_re = cau_pkg::sat(r_s2.m_re >>> FW);
                w_sat_im = cau_pkg::sat(r_s2.m_im >>> FW);
            end
            default: begin
                w_sat_re = '0;
                w_sat_im = '0;
            end
        endcase

        n_s3.is_div  = (r_s2.op == cau_pkg::OP_DIV);
        n_s3.dbz     = (r_s2.den == '0);
        n_s3.dovf_re = (RW'(w_top_re) >= r_s2.den);
        n_s3.dovf_im = (RW'(w_top_im) >= r_s2.den);
        n_s3.neg_re  = r_s2.d_re[SW-1];
        n_s3.neg_im  = r_s2.d_im[SW-1];
        n_s3.rem_re  = RW'(w_top_re);
        n_s3.rem_im  = RW'(w_top_im);
        n_s3.nlo_re  = w_big_re[QB-1:0];
        n_s3.nlo_im  = w_big_im[QB-1:0];
        n_s3.q_re    = '0;
        n_s3.q_im    = '0;
        n_s3.den     = r_s2.den;
        n_s3.pre_re  = w_sat_re.val;
        n_s3.pre_im  = w_sat_im.val;
        n_s3.pre_ovf = w_sat_re.ovf || w_sat_im.ovf;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    // Payload: load only on a moving, valid item
    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) r_s1 <= n_s1;
        if (w_rdy2 && r_v1)    r_s2 <= n_s2;
        if (w_rdy3 && r_v2)    r_s3 <= n_s3;
    end

endmodule

### design/cau_div_stage.sv
// One restoring-division step for both quotient parts.
module cau_div_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  cau_pkg::t_div_item  i_data,
    output logic                o_ready,
    output logic                o_valid,
    output cau_pkg::t_div_item  o_data,
    input  logic                i_ready
);

    localparam int RW = cau_pkg::RW;
    localparam int QB = cau_pkg::QB;

    logic               r_v;
    cau_pkg::t_div_item r_d, n_d;
    logic               w_rdy;
    logic [RW:0]        w_t_re, w_t_im, w_dd;
    logic               w_ge_re, w_ge_im;

    assign w_rdy   = !r_v || i_ready;
    assign o_ready = w_rdy;
    assign o_valid = r_v;
    assign o_data  = r_d;

    // Shift in the next numerator bit, subtract the divisor where it fits
    always_comb begin
        w_dd    = {1'b0, i_data.den};
        w_t_re  = {i_data.rem_re, i_data.nlo_re[QB-1]};
        w_t_im  = {i_data.rem_im, i_data.nlo_im[QB-1]};
        w_ge_re = (w_t_re >= w_dd);
        w_ge_im = (w_t_im >= w_dd);

        n_d        = i_data;
        n_d.rem_re = w_ge_re ? RW'(w_t_re - w_dd) : w_t_re[RW-1:0];
        n_d.rem_im = w_ge_im ? RW'(w_t_im - w_dd) : w_t_im[RW-1:0];
        n_d.nlo_re = i_data.nlo_re << 1;
        n_d.nlo_im = i_data.nlo_im << 1;
        n_d.q_re   = {i_data.q_re[QB-2:0], w_ge_re};
        n_d.q_im   = {i_data.q_im[QB-2:0], w_ge_im};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy && i_valid) r_d <= n_d;
    end

    // Remainder of a live division stays below the divisor
    a_rem_re: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v && r_d.is_div && !r_d.dbz && !r_d.dovf_re |-> r_d.rem_re < r_d.den)
        else $error("real remainder not below divisor");
    a_rem_im: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v && r_d.is_div && !r_d.dbz && !r_d.dovf_im |-> r_d.rem_im < r_d.den)
        else $error("imaginary remainder not below divisor");
    // Divisor travels unchanged through the step
    a_den_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rdy && i_valid |=> r_d.den == $past(i_data.den))
        else $error("divisor changed in divider step");

endmodule

### design/cau_back.sv
// Output stage: sign, saturate and select the final result.
module cau_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  cau_pkg::t_div_item  i_data,
    output logic                o_ready,
    output logic                o_valid,
    output cau_pkg::t_out_item  o_data,
    input  logic                i_ready
);

    localparam int SW = cau_pkg::SW;
    localparam int QB = cau_pkg::QB;

    logic               r_v;
    cau_pkg::t_out_item r_d, n_d;
    logic               w_rdy;
    cau_pkg::t_sat      w_re, w_im;

    assign w_rdy   = !r_v || i_ready;
    assign o_ready = w_rdy;
    assign o_valid = r_v;
    assign o_data  = r_d;

    // Turn a quotient magnitude into a saturated signed part
    function automatic cau_pkg::t_sat part(input logic neg, input logic dovf,
                                           input logic [QB-1:0] q);
        cau_pkg::t_sat       s;
        logic signed [SW-1:0] v;
        v = SW'(q);
        if (neg) v = -v;
        if (dovf) begin
            s.ovf = 1'b1;
            s.val = neg ? cau_pkg::SAT_LO[cau_pkg::DW-1:0] : cau_pkg::SAT_HI[cau_pkg::DW-1:0];
        end else begin
            s = cau_pkg::sat(v);
        end
        return s;
    endfunction

    always_comb begin
        w_re = part(i_data.neg_re, i_data.dovf_re, i_data.q_re);
        w_im = part(i_data.neg_im, i_data.dovf_im, i_data.q_im);
        if (!i_data.is_div) begin
            n_d.res_re      = i_data.pre_re;
            n_d.res_im      = i_data.pre_im;
            n_d.overflow    = i_data.pre_ovf;
            n_d.div_by_zero = 1'b0;
        end else if (i_data.dbz) begin
            n_d.res_re      = '0;
            n_d.res_im      = '0;
            n_d.overflow    = 1'b0;
            n_d.div_by_zero = 1'b1;
        end else begin
            n_d.res_re      = w_re.val;
            n_d.res_im      = w_im.val;
            n_d.overflow    = w_re.ovf || w_im.ovf;
            n_d.div_by_zero = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy && i_valid) r_d <= n_d;
    end

endmodule

### design/complex_arithmetic_unit.sv
// Top level of the pipelined complex add, subtract, multiply and divide unit.
//
//  channel  | valid    | ready    | payload
//  ---------+----------+----------+-------------------------------------------
//  input    | i_valid  | o_ready  | i_data : opcode, a_re, a_im, b_re, b_im
//  output   | o_valid  | i_ready  | o_data : res_re, res_im, overflow, div_by_zero
//
// One transfer in and one out per cycle while i_ready stays high; from input to
// output every item passes three product and sum stages, one divider stage per
// quotient bit (33), and one output stage. The 33 subtract-and-compare steps
// of the divider set the depth. Reset empties every stage. A stall holds each
// full stage; empty stages ahead of it keep filling, so bubbles close up.
module complex_arithmetic_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  cau_pkg::t_in_item   i_data,
    output logic                o_ready,
    output logic                o_valid,
    output cau_pkg::t_out_item  o_data,
    input  logic                i_ready
);

    localparam int QB = cau_pkg::QB;

    logic               w_v   [0:QB];
    logic               w_r   [0:QB];
    cau_pkg::t_div_item w_d   [0:QB];

    cau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_ready (o_ready),
        .o_valid (w_v[0]),
        .o_data  (w_d[0]),
        .i_ready (w_r[0])
    );

    // One divider step per quotient bit, most significant first
    for (genvar k = 0; k < QB; k++) begin : g_div
        cau_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[k]),
            .i_data  (w_d[k]),
            .o_ready (w_r[k]),
            .o_valid (w_v[k+1]),
            .o_data  (w_d[k+1]),
            .i_ready (w_r[k+1])
        );
    end

    cau_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v[QB]),
        .i_data  (w_d[QB]),
        .o_ready (w_r[QB]),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_ready (i_ready)
    );

    // A zero divisor gives a clean zero result
    a_dbz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.div_by_zero |->
            (o_data.res_re == '0) && (o_data.res_im == '0) && !o_data.overflow)
        else $error("divide by zero result not zero");
    // Nothing comes out right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
    // An empty output register always takes the next item
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> w_r[QB])
        else $error("empty output stage not ready");

endmodule

### sim/complex_arithmetic_unit_tb.sv
// Self-checking testbench for the complex arithmetic unit: driver, monitor and predictor.
module complex_arithmetic_unit_tb;

    localparam int LATENCY    = 37;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_LEN   = 300;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    cau_pkg::t_in_item   i_data;
    logic                o_ready;
    logic                o_valid;
    cau_pkg::t_out_item  o_data;
    logic                i_ready;

    cau_pkg::t_in_item   pending_ops[$];
    cau_pkg::t_out_item  expected_results[$];
    int         mismatch_count;
    int         result_count;
    int         div_count;
    int         ovf_count;
    int         idle_cycles;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         hold_cycles;
    bit         hold_request;

    complex_arithmetic_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_ready (i_ready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Saturate a wide exact value to one result part
    function automatic logic signed [31:0] clamp_part(input logic signed [159:0] v,
                                                      inout logic ovf);
        logic signed [159:0] hi;
        logic signed [159:0] lo;
        hi = 160'sd2147483647;
        lo = -160'sd2147483648;
        if (v > hi) begin
            ovf = 1'b1;
            return hi[31:0];
        end else if (v < lo) begin
            ovf = 1'b1;
            return lo[31:0];
        end
        return v[31:0];
    endfunction

    // Quotient truncated toward zero, divisor positive
    function automatic logic signed [159:0] trunc_div(input logic signed [159:0] n,
                                                      input logic signed [159:0] d);
        logic [159:0] mag;
        mag = (n < 0) ? -n : n;
        mag = mag / d;
        return (n < 0) ? -$signed(mag) : $signed(mag);
    endfunction

    // Work out the complex result of one operation
    function automatic cau_pkg::t_out_item complex_result(input cau_pkg::t_in_item it);
        cau_pkg::t_out_item r;
        logic signed [159:0] ar, ai, br, bi, rr, ri, den, nr, ni;
        logic ovf;
        ar = 160'(it.a_re);
        ai = 160'(it.a_im);
        br = 160'(it.b_re);
        bi = 160'(it.b_im);
        ovf = 1'b0;
        r.div_by_zero = 1'b0;
        case (it.opcode)
            cau_pkg::OP_ADD: begin
                rr = ar + br;
                ri = ai + bi;
            end
            cau_pkg::OP_SUB: begin
                rr = ar - br;
                ri = ai - bi;
            end
            cau_pkg::OP_MUL: begin
                rr = (ar * br - ai * bi) >>> 16;
                ri = (ai * br + ar * bi) >>> 16;
            end
            default: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.div_by_zero = 1'b1;
                    rr = 0;
                    ri = 0;
                end else begin
                    nr = (ar * br + ai * bi) <<< 16;
                    ni = (ai * br - ar * bi) <<< 16;
                    rr = trunc_div(nr, den);
                    ri = trunc_div(ni, den);
                end
            end
        endcase
        r.res_re = clamp_part(rr, ovf);
        r.res_im = clamp_part(ri, ovf);
        r.overflow = ovf;
        return r;
    endfunction

    function automatic logic signed [31:0] rand_part();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return 32'sd0;
            3: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic cau_pkg::t_in_item make_op(input cau_pkg::t_op op,
                                                  input logic signed [31:0] ar,
                                                  input logic signed [31:0] ai,
                                                  input logic signed [31:0] br,
                                                  input logic signed [31:0] bi);
        cau_pkg::t_in_item it;
        it.opcode = op;
        it.a_re = ar;
        it.a_im = ai;
        it.b_re = br;
        it.b_im = bi;
        return it;
    endfunction

    // Report one mismatch and count it
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("Mismatch on %s: got %h, expected %h", what, got, want);
        mismatch_count++;
    endtask

    // Driver: offer the queue head, hold it until transferred
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                expected_results.push_back(complex_result(i_data));
            end
            if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_valid <= 1'b1;
                i_data <= pending_ops.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver ready, with random stalls and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            hold_cycles <= 0;
        end else if (hold_request && hold_cycles < HOLD_LEN) begin
            i_ready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: compare each transferred result with the oldest expectation
    always @(posedge i_clk) begin
        cau_pkg::t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            result_count++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", o_data.res_re, 32'h0);
            end else begin
                want = expected_results.pop_front();
                if (want.div_by_zero) div_count++;
                if (want.overflow) ovf_count++;
                if (o_data.res_re !== want.res_re)
                    report_mismatch("res_re", o_data.res_re, want.res_re);
                if (o_data.res_im !== want.res_im)
                    report_mismatch("res_im", o_data.res_im, want.res_im);
                if (o_data.overflow !== want.overflow)
                    report_mismatch("overflow", 32'(o_data.overflow), 32'(want.overflow));
                if (o_data.div_by_zero !== want.div_by_zero)
                    report_mismatch("div_by_zero", 32'(o_data.div_by_zero),
                                    32'(want.div_by_zero));
            end
        end
    end

    // Watchdog: end the run when nothing transfers for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout with no transfer");
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic drain_queues();
        while (pending_ops.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic load_random(input int count);
        cau_pkg::t_op op;
        repeat (count) begin
            op = cau_pkg::t_op'($urandom_range(0, 3));
            if (op == cau_pkg::OP_DIV && $urandom_range(0, 9) == 0)
                pending_ops.push_back(make_op(op, rand_part(), rand_part(), 0, 0));
            else
                pending_ops.push_back(make_op(op, rand_part(), rand_part(),
                                              rand_part(), rand_part()));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_data = '0;
        mismatch_count = 0;
        result_count = 0;
        div_count = 0;
        ovf_count = 0;
        idle_cycles = 0;
        hold_request = 1'b0;
        send_idle_pct = 31;
        recv_idle_pct = 78;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every operation, saturation and zero divisor
        pending_ops.push_back(make_op(cau_pkg::OP_ADD, 32'sh7FFFFFFF, 32'sh80000000,
                                      32'sh7FFFFFFF, 32'sh80000000));
        pending_ops.push_back(make_op(cau_pkg::OP_ADD, 32'sh00010000, -32'sh00020000,
                                      32'sh00008000, 32'sh00000001));
        pending_ops.push_back(make_op(cau_pkg::OP_SUB, 32'sh80000000, 32'sh7FFFFFFF,
                                      32'sh7FFFFFFF, 32'sh80000000));
        pending_ops.push_back(make_op(cau_pkg::OP_SUB, 32'sh0, 32'sh0, 32'sh0, 32'sh0));
        pending_ops.push_back(make_op(cau_pkg::OP_MUL, 32'sh00010000, 32'sh00010000,
                                      32'sh00010000, -32'sh00010000));
        pending_ops.push_back(make_op(cau_pkg::OP_MUL, 32'sh80000000, 32'sh80000000,
                                      32'sh80000000, 32'sh80000000));
        pending_ops.push_back(make_op(cau_pkg::OP_MUL, 32'sh7FFFFFFF, 32'sh80000000,
                                      32'sh7FFFFFFF, 32'sh7FFFFFFF));
        pending_ops.push_back(make_op(cau_pkg::OP_MUL, -32'sd1, 32'sd1, 32'sd1, 32'sd1));
        pending_ops.push_back(make_op(cau_pkg::OP_DIV, 32'sh00010000, 32'sh0,
                                      32'sh0, 32'sh0));
        pending_ops.push_back(make_op(cau_pkg::OP_DIV, 32'sh80000000, 32'sh80000000,
                                      32'sh0, 32'sh0));
        pending_ops.push_back(make_op(cau_pkg::OP_DIV, 32'sh00030000, -32'sh00010000,
                                      32'sh00010000, 32'sh00020000));
        pending_ops.push_back(make_op(cau_pkg::OP_DIV, -32'sd1, 32'sd1,
                                      32'sh00030000, 32'sh0));
        pending_ops.push_back(make_op(cau_pkg::OP_DIV, 32'sh7FFFFFFF, 32'sh80000000,
                                      32'sd1, 32'sd0));
        pending_ops.push_back(make_op(cau_pkg::OP_DIV, 32'sh80000000, 32'sh7FFFFFFF,
                                      32'sh80000000, 32'sh80000000));
        pending_ops.push_back(make_op(cau_pkg::OP_DIV, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                      32'sd0, -32'sd1));
        load_random(235);
        drain_queues();

        // Swap idling, and hold the receiver off while the input fills
        send_idle_pct = 78;
        recv_idle_pct = 31;
        load_random(250);
        hold_request = 1'b1;
        drain_queues();

        // Full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_random(250);
        drain_queues();
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("Checked %0d results over add, subtract, multiply and divide,", result_count);
        $display("including %0d zero divisors and %0d saturated results.", div_count, ovf_count);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
